[hdl/grey_nibble_pixel_packer_core_defines.svh]
// Assertion macros shared by the grey nibble pixel packer RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef GREY_NIBBLE_PIXEL_PACKER_CORE_DEFINES_SVH
`define GREY_NIBBLE_PIXEL_PACKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked property, ignored while reset is high.
`define GNPP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, evaluated during reset as well.
`define GNPP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GNPP_ASSERT(lbl, clk, rst, prop, msg)
`define GNPP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[hdl/gnpp_pkg.sv]
// Package for the grey nibble pixel packer: payload and job types,
// register codes, sizing constants and the pixel conversion functions.
`default_nettype none

package gnpp_pkg;

  localparam int MAX_SEGMENTS = 4;
  localparam int SEGS_W       = $clog2(MAX_SEGMENTS + 1);
  localparam int SEG_IDX_W    = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT      = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENTS_PER_PIX  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SWAP_BYTES        = 2'd2;

  localparam logic FMT_MONO   = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  localparam logic [1:0] LAST_PAIR = 2'd3;

  typedef struct packed {
    logic [15:0] pixel_word;
    logic        row_first;
    logic        row_last;
    logic        start_odd;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } pix_out_t;

  // One unit of work for the back end: a finished byte, or a mono byte to expand
  typedef struct packed {
    logic              mono;
    logic [7:0]        data;
    logic [SEGS_W-1:0] segs;
  } job_t;

  function automatic logic [3:0] grey_of(input logic [15:0] word, input logic swap);
    logic [15:0] px;
    logic [8:0]  sum;
    px  = swap ? {word[7:0], word[15:8]} : word;
    sum = ({4'b0, px[15:11]} * 9'd3) + ({3'b0, px[10:5]} * 9'd6) + {4'b0, px[4:0]};
    return sum[8:5];
  endfunction

  function automatic logic [7:0] mono_pair(input logic [7:0] byte_in, input logic [1:0] pair);
    logic even_bit;
    logic odd_bit;
    even_bit = byte_in[{pair, 1'b0}];
    odd_bit  = byte_in[{pair, 1'b1}];
    return {(even_bit ? 4'h0 : 4'hF), (odd_bit ? 4'h0 : 4'hF)};
  endfunction

  function automatic logic [SEGS_W-1:0] clamp_segs(input logic [CFG_DATA_W-1:0] raw);
    logic [SEGS_W-1:0] segs;
    if (raw == '0) begin
      segs = SEGS_W'(1);
    end else if (int'(raw) > MAX_SEGMENTS) begin
      segs = SEGS_W'(MAX_SEGMENTS);
    end else begin
      segs = SEGS_W'(raw);
    end
    return segs;
  endfunction

endpackage

`default_nettype wire

[hdl/gnpp_front.sv]
// Front end: configuration registers, input acceptance, grey conversion,
// row pairing state and job generation. Depends on gnpp_pkg.
`default_nettype none

module gnpp_front (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gnpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [gnpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_stall,
  input  wire gnpp_pkg::pix_in_t               pixel,
  input  wire logic                            q_full,
  output logic                                 q_push,
  output gnpp_pkg::job_t                       q_job
);
  import gnpp_pkg::*;

  logic                  pixel_format;
  logic [CFG_DATA_W-1:0] seg_repeat;
  logic                  swap_bytes;
  logic                  pending_valid;
  logic [3:0]            pending_level;
  logic                  pending_valid_next;
  logic [3:0]            pending_level_next;
  logic                  accept;
  logic [3:0]            grey;

  assign cfg_ready   = 1'b1;
  assign pixel_stall = q_full;
  assign accept      = pixel_valid && !q_full;
  assign grey        = grey_of(pixel.pixel_word, swap_bytes);

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_MONO;
      seg_repeat   <= CFG_DATA_W'(1);
      swap_bytes   <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_PIXEL_FORMAT:     pixel_format <= cfg_data[0];
        CFG_SEGMENTS_PER_PIX: seg_repeat   <= cfg_data;
        CFG_SWAP_BYTES:       swap_bytes   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pending_valid_next = pending_valid;
    pending_level_next = pending_level;
    q_push             = 1'b0;
    q_job.mono         = 1'b0;
    q_job.data         = 8'h00;
    q_job.segs         = SEGS_W'(1);
    if (accept) begin
      if (pixel_format == FMT_MONO) begin
        q_push     = 1'b1;
        q_job.mono = 1'b1;
        q_job.data = pixel.pixel_word[7:0];
        q_job.segs = clamp_segs(seg_repeat);
      end else if (pixel.row_first && pixel.start_odd) begin
        // odd start: lone grey in the low nibble, drop anything held
        q_push             = 1'b1;
        q_job.data         = {4'h0, grey};
        pending_valid_next = 1'b0;
        pending_level_next = 4'h0;
      end else if (pending_valid && !pixel.row_first) begin
        q_push             = 1'b1;
        q_job.data         = {pending_level, grey};
        pending_valid_next = 1'b0;
        pending_level_next = 4'h0;
      end else if (pixel.row_last) begin
        q_push             = 1'b1;
        q_job.data         = {grey, 4'h0};
        pending_valid_next = 1'b0;
        pending_level_next = 4'h0;
      end else begin
        pending_valid_next = 1'b1;
        pending_level_next = grey;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_valid <= 1'b0;
      pending_level <= 4'h0;
    end else begin
      pending_valid <= pending_valid_next;
      pending_level <= pending_level_next;
    end
  end

endmodule

`default_nettype wire

[hdl/gnpp_queue.sv]
// Short job queue between the front and back ends.
// Depends on gnpp_pkg for the job type and depth.
`default_nettype none

module gnpp_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire gnpp_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                avail,
  output gnpp_pkg::job_t      head
);
  import gnpp_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign full    = (count == QCNT_W'(QUEUE_DEPTH));
  assign avail   = (count != '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/gnpp_back.sv]
// Back end: drains jobs from the queue, expands mono bytes into bit-pair
// runs and holds each result in the output register. Depends on gnpp_pkg.
`default_nettype none
`include "grey_nibble_pixel_packer_core_defines.svh"

module gnpp_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_avail,
  input  wire gnpp_pkg::job_t q_job,
  output logic                q_pop,
  output logic                result_valid,
  input  wire logic           result_stall,
  output gnpp_pkg::pix_out_t  result
);
  import gnpp_pkg::*;

  logic [1:0]           pair;
  logic [SEG_IDX_W-1:0] seg;
  logic                 advance;
  logic                 emit;
  logic                 seg_end;
  logic                 run_end;
  logic [7:0]           byte_now;

  assign advance  = !result_valid || !result_stall;
  assign emit     = advance && q_avail;
  assign seg_end  = (SEGS_W'(seg) == q_job.segs - 1'b1);
  assign run_end  = !q_job.mono || (seg_end && pair == LAST_PAIR);
  assign q_pop    = emit && run_end;
  assign byte_now = q_job.mono ? mono_pair(q_job.data, pair) : q_job.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      pair         <= 2'd0;
      seg          <= '0;
    end else begin
      if (advance) begin
        result_valid <= q_avail;
      end
      if (emit && q_job.mono) begin
        // step the segment repeat, then the bit pair; both wrap at run end
        if (seg_end) begin
          seg  <= '0;
          pair <= pair + 1'b1;
        end else begin
          seg <= seg + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result.out_byte    <= byte_now;
      result.last_of_run <= run_end;
    end
  end

  `GNPP_ASSERT(a_seg_in_range, clk, rst, (q_avail && q_job.mono) |-> (SEGS_W'(seg) < q_job.segs), "segment count past repeat limit")
  `GNPP_ASSERT(a_idle_counters, clk, rst, !q_avail |-> (pair == 2'd0 && seg == '0), "run counters not parked between jobs")
  `GNPP_ASSERT(a_last_marks_pop, clk, rst, (emit && run_end) |=> (result_valid && result.last_of_run), "run end not marked on output")
  `GNPP_ASSERT_ALWAYS(a_reset_clears, clk, $past(rst) |-> !result_valid, "output valid after reset")

endmodule

`default_nettype wire

[hdl/grey_nibble_pixel_packer_core.sv]
// Grey nibble pixel packer, top level: ties front end, job queue and back end.
// Depends on gnpp_pkg, gnpp_front, gnpp_queue and gnpp_back.
//
// Usage:
//   pixel channel (pixel_valid / pixel_stall / pixel) carries one input item per
//   transaction. result channel (result_valid / result_stall / result) carries one
//   output byte per transaction, last_of_run marking the final byte of an input.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data) writes pixel format
//   (index 0), segment repeat count (1) and byte swap (2); cfg_ready is always
//   high. Write only while idle.
// Data path: an accepted input's job is written into the job queue, and the back end
//   then registers its result in the output register.
// Throughput: RGB565 items flow at one per cycle while the receiver does not stall.
//   A mono item expands into 4 * repeat count output bytes, one per cycle while the
//   receiver does not stall; the input stalls once the two-entry job queue fills behind it.
// Reset (synchronous, rst high): queue emptied, output invalid, pending grey
//   cleared, registers to mono, one segment, no swap.
// Receiver stall: the output byte holds; the queue absorbs up to two jobs, then
//   pixel_stall rises until the receiver takes data again.
`default_nettype none

module grey_nibble_pixel_packer_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gnpp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [gnpp_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            pixel_valid,
  output logic                                 pixel_stall,
  input  wire gnpp_pkg::pix_in_t               pixel,
  output logic                                 result_valid,
  input  wire logic                            result_stall,
  output gnpp_pkg::pix_out_t                   result
);
  import gnpp_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_avail;
  job_t push_job;
  job_t head_job;

  gnpp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (push_job)
  );

  gnpp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .full     (q_full),
    .avail    (q_avail),
    .head     (head_job)
  );

  gnpp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_avail      (q_avail),
    .q_job        (head_job),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

[tb/tb_grey_nibble_pixel_packer_core.sv]
// Self-checking testbench for grey_nibble_pixel_packer_core: RGB565 and mono
// streams with random idling, predicted bytes checked in order by a scoreboard.
// Depends on gnpp_pkg and the packer RTL only.
`timescale 1ns / 1ps

module tb_grey_nibble_pixel_packer_core;
  import gnpp_pkg::*;

  localparam int ITEM_TARGET  = 500;
  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 200;
  localparam int HOLD_AT      = 260;
  localparam int PHASE_ITEMS  = 40;

  // Predicts the display bytes for each pixel transaction and checks them in order
  class grey_byte_board;
    pix_out_t        want_q[$];
    int              errors;
    int              checked;
    logic            fmt;
    logic [2:0]      seg_raw;
    logic            swap;
    logic            held_valid;
    logic [3:0]      held_level;

    function new();
      errors     = 0;
      checked    = 0;
      fmt        = FMT_MONO;
      seg_raw    = 3'd1;
      swap       = 1'b0;
      held_valid = 1'b0;
      held_level = 4'h0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PIXEL_FORMAT: begin
          fmt = val[0];
        end
        CFG_SEGMENTS_PER_PIX: begin
          seg_raw = val;
        end
        CFG_SWAP_BYTES: begin
          swap = val[0];
        end
        default: begin
        end
      endcase
    endfunction

    function int outstanding();
      return want_q.size();
    endfunction

    function void queue_byte(logic [7:0] val, logic fin);
      pix_out_t o;
      o.out_byte    = val;
      o.last_of_run = fin;
      want_q.push_back(o);
    endfunction

    function logic [3:0] grey_level(logic [15:0] w);
      logic [15:0] px;
      int r;
      int g;
      int b;
      px = swap ? {w[7:0], w[15:8]} : w;
      r  = int'(px[15:11]);
      g  = int'(px[10:5]);
      b  = int'(px[4:0]);
      return 4'((3 * r + 6 * g + b) >> 5);
    endfunction

    function void note_pixel(pix_in_t it);
      logic [3:0] g;
      logic [3:0] hi;
      logic [3:0] lo;
      logic [7:0] mono_in;
      int         reps;
      int         p;
      int         s;
      if (fmt == FMT_MONO) begin
        mono_in = it.pixel_word[7:0];
        reps    = int'(seg_raw);
        if (reps == 0) reps = 1;
        if (reps > MAX_SEGMENTS) reps = MAX_SEGMENTS;
        for (p = 0; p < 4; p++) begin
          hi = mono_in[2 * p] ? 4'h0 : 4'hF;
          lo = mono_in[2 * p + 1] ? 4'h0 : 4'hF;
          for (s = 0; s < reps; s++) begin
            queue_byte({hi, lo}, (p == 3) && (s == reps - 1));
          end
        end
        return;
      end
      g = grey_level(it.pixel_word);
      if (it.row_first) begin
        // a grey still held from the previous row is dropped
        held_valid = 1'b0;
        held_level = 4'h0;
        if (it.start_odd) begin
          queue_byte({4'h0, g}, 1'b1);
          return;
        end
      end
      if (held_valid) begin
        queue_byte({held_level, g}, 1'b1);
        held_valid = 1'b0;
        held_level = 4'h0;
      end else if (it.row_last) begin
        queue_byte({g, 4'h0}, 1'b1);
      end else begin
        held_valid = 1'b1;
        held_level = g;
      end
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    task check_byte(pix_out_t got);
      pix_out_t want;
      if (want_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last_of_run));
        return;
      end
      want = want_q.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0b, want %0b", got.last_of_run, want.last_of_run));
    endtask

    task finish_check();
      if (want_q.size() != 0)
        report($sformatf("%0d expected bytes never arrived", want_q.size()));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   pixel_valid;
  logic                   pixel_stall;
  pix_in_t                pixel;
  logic                   packed_valid;
  logic                   packed_stall;
  pix_out_t               packed_item;

  grey_byte_board board;
  int             items_sent = 0;
  int             reg_writes = 0;
  logic           quiet_stretch;
  logic           hold_go;

  assign quiet_stretch = (items_sent >= 100) && (items_sent < 180);

  grey_nibble_pixel_packer_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (packed_valid),
    .result_stall (packed_stall),
    .result       (packed_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && packed_valid && !packed_stall) board.check_byte(packed_item);
  end

  function automatic logic [15:0] rand_word();
    logic [15:0] w;
    case ($urandom_range(9))
      0: w = 16'h0000;
      1: w = 16'hFFFF;
      default: w = 16'($urandom());
    endcase
    return w;
  endfunction

  task automatic send(input logic [15:0] w, input logic f, input logic l, input logic o);
    pix_in_t it;
    it.pixel_word = w;
    it.row_first  = f;
    it.row_last   = l;
    it.start_odd  = o;
    if (!quiet_stretch) begin
      while ($urandom_range(99) < 15) begin
        pixel_valid <= 1'b0;
        @(posedge clk);
      end
    end
    pixel       <= it;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    board.note_pixel(it);
    items_sent++;
  endtask

  // Well-formed row: first flag on the opening pixel, last flag on the closing one
  task automatic send_row(input int len);
    logic odd;
    int   i;
    odd = 1'($urandom_range(1));
    for (i = 0; i < len; i++) begin
      send(rand_word(), i == 0, i == len - 1, (i == 0) ? odd : 1'($urandom_range(1)));
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val);
    reg_writes++;
  endtask

  // Drain, give a pixel that only stores a grey time to settle, then reprogram
  task automatic apply_setting(input logic fmt, input logic [2:0] segs, input logic swp);
    pixel_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    write_reg(CFG_PIXEL_FORMAT, {2'b00, fmt});
    write_reg(CFG_SEGMENTS_PER_PIX, segs);
    write_reg(CFG_SWAP_BYTES, {2'b00, swp});
    cfg_valid <= 1'b0;
  endtask

  initial begin : receiver
    bit held_once;
    held_once = 1'b0;
    packed_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (!held_once && hold_go) begin
        // long hold-off: the sender keeps offering until the block backs up
        held_once = 1'b1;
        packed_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet_stretch) begin
        packed_stall <= 1'b0;
      end else begin
        packed_stall <= ($urandom_range(99) < 15);
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (pixel_valid && !pixel_stall) || (packed_valid && !packed_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic       fmt;
    logic [2:0] segs;
    int         phase_end;
    board = new();
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    pixel_valid <= 1'b0;
    pixel       <= '0;
    hold_go     <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // mono: all-set and all-clear bytes, upper bits and row flags ignored
    apply_setting(FMT_MONO, 3'd1, 1'b0);
    send(16'h0000, 1'b0, 1'b0, 1'b0);
    send(16'h00FF, 1'b0, 1'b0, 1'b0);
    send(16'hFF5A, 1'b1, 1'b1, 1'b1);
    apply_setting(FMT_MONO, 3'd4, 1'b0);
    send(16'h00C3, 1'b0, 1'b0, 1'b0);
    // segment count of zero and above the maximum
    apply_setting(FMT_MONO, 3'd0, 1'b0);
    send(16'h0012, 1'b0, 1'b0, 1'b0);
    apply_setting(FMT_MONO, 3'd7, 1'b1);
    send(16'h0081, 1'b0, 1'b1, 1'b0);

    apply_setting(FMT_RGB565, 3'd1, 1'b0);
    send(16'h0000, 1'b1, 1'b0, 1'b0);
    send(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send(16'hF800, 1'b0, 1'b0, 1'b0);
    send(16'h07E0, 1'b0, 1'b1, 1'b0);
    // odd start: lone grey in the low nibble, then pairs
    send(16'h001F, 1'b1, 1'b0, 1'b1);
    send(16'hFFFF, 1'b0, 1'b0, 1'b0);
    send(16'h1234, 1'b0, 1'b1, 1'b0);
    // odd start on a one-pixel row
    send(16'hFFFF, 1'b1, 1'b1, 1'b1);
    // pending grey flushed at row end
    send(16'h8410, 1'b1, 1'b0, 1'b0);
    send(16'h4208, 1'b0, 1'b0, 1'b0);
    send(16'hFFFF, 1'b0, 1'b1, 1'b0);
    // held grey dropped by a new row start
    send(16'hABCD, 1'b1, 1'b0, 1'b0);
    send(16'h5555, 1'b1, 1'b0, 1'b0);
    send(16'h0F0F, 1'b0, 1'b1, 1'b0);
    apply_setting(FMT_RGB565, 3'd1, 1'b1);
    send(16'h00F8, 1'b1, 1'b0, 1'b0);
    send(16'hE007, 1'b0, 1'b1, 1'b0);
    send(16'hFFFF, 1'b1, 1'b1, 1'b0);

    while (items_sent < ITEM_TARGET) begin
      fmt  = ($urandom_range(99) < 65) ? FMT_RGB565 : FMT_MONO;
      segs = ($urandom_range(99) < 75) ? 3'($urandom_range(2, 1)) : 3'($urandom_range(7));
      apply_setting(fmt, segs, 1'($urandom_range(1)));
      // start the receiver hold-off at the opening of a phase so the sender keeps going
      if (items_sent >= HOLD_AT) hold_go <= 1'b1;
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end) begin
        if (fmt == FMT_RGB565 && $urandom_range(99) < 85)
          send_row($urandom_range(10, 1));
        else
          send(rand_word(), 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)));
      end
    end

    pixel_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    board.finish_check();
    $display("Run covered %0d pixel transactions and %0d register writes,", items_sent,
             reg_writes);
    $display("with %0d output bytes checked in mono and RGB565 modes.", board.checked);
    if (board.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/gnpp_pkg.sv
hdl/gnpp_front.sv
hdl/gnpp_queue.sv
hdl/gnpp_back.sv
hdl/grey_nibble_pixel_packer_core.sv
tb/tb_grey_nibble_pixel_packer_core.sv
